[rtl/table_waveform_generator_top_assert.svh]
// Assertion macros shared by the waveform generator RTL.
`ifndef TABLE_WAVEFORM_GENERATOR_TOP_ASSERT_SVH
`define TABLE_WAVEFORM_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define TWG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TWG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/twg_pkg.sv]
// ----------------------------------------------------------------------------
// twg_pkg
// Types, constants and waveform tables of the table waveform generator.
// ----------------------------------------------------------------------------
`default_nettype none

package twg_pkg;

   localparam int TABLE_LEN  = 60;
   localparam int INDEX_W    = $clog2(TABLE_LEN);
   localparam int NUM_LEVELS = 5;
   localparam int LEVEL_W    = 3;
   localparam int PERIOD_W   = 16;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [LEVEL_W-1:0]  MAX_LEVEL = LEVEL_W'(NUM_LEVELS - 1);
   localparam logic [PERIOD_W-1:0] TICK_MAX  = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_ZERO  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_ONE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_TWO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_THREE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_FOUR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND      = 3'd5;

   localparam logic [BYTE_W-1:0] COMMAND_RESET = 8'h11;

   // key codes
   localparam logic [BYTE_W-1:0] KEY_FASTER   = 8'h2B;  // '+'
   localparam logic [BYTE_W-1:0] KEY_SLOWER   = 8'h2D;  // '-'
   localparam logic [BYTE_W-1:0] KEY_TRIANGLE = 8'h74;  // 't'
   localparam logic [BYTE_W-1:0] KEY_SQUARE   = 8'h63;  // 'c'
   localparam logic [BYTE_W-1:0] KEY_SINE     = 8'h73;  // 's'

   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_KEY  = 1'b1;

   localparam logic [1:0] WAVE_SINE     = 2'd0;
   localparam logic [1:0] WAVE_SQUARE   = 2'd1;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd2;

   typedef struct packed {
      logic              action;
      logic [BYTE_W-1:0] key_char;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] spi_byte;
      logic              frame_last;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] sample;
   } frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } push_type;

   localparam logic [BYTE_W-1:0] SINE_TAB [0:TABLE_LEN-1] = '{
      8'd254, 8'd254, 8'd252, 8'd249, 8'd244, 8'd238, 8'd231, 8'd222, 8'd213, 8'd202,
      8'd191, 8'd179, 8'd167, 8'd154, 8'd141, 8'd127, 8'd114, 8'd101, 8'd88,  8'd76,
      8'd64,  8'd53,  8'd42,  8'd33,  8'd24,  8'd17,  8'd11,  8'd6,   8'd3,   8'd1,
      8'd0,   8'd1,   8'd3,   8'd6,   8'd11,  8'd17,  8'd24,  8'd33,  8'd42,  8'd53,
      8'd64,  8'd76,  8'd88,  8'd101, 8'd114, 8'd128, 8'd141, 8'd154, 8'd167, 8'd179,
      8'd191, 8'd202, 8'd213, 8'd222, 8'd231, 8'd238, 8'd244, 8'd249, 8'd252, 8'd254
   };

   localparam logic [BYTE_W-1:0] TRIANGLE_TAB [0:TABLE_LEN-1] = '{
      8'd9,   8'd17,  8'd26,  8'd34,  8'd43,  8'd51,  8'd60,  8'd68,  8'd77,  8'd85,
      8'd94,  8'd102, 8'd111, 8'd119, 8'd128, 8'd136, 8'd145, 8'd153, 8'd162, 8'd170,
      8'd179, 8'd187, 8'd196, 8'd204, 8'd213, 8'd221, 8'd230, 8'd238, 8'd247, 8'd255,
      8'd247, 8'd238, 8'd230, 8'd221, 8'd213, 8'd204, 8'd196, 8'd187, 8'd179, 8'd170,
      8'd162, 8'd153, 8'd145, 8'd136, 8'd128, 8'd119, 8'd111, 8'd102, 8'd94,  8'd86,
      8'd77,  8'd68,  8'd60,  8'd51,  8'd43,  8'd34,  8'd26,  8'd17,  8'd9,   8'd0
   };

   function automatic logic [BYTE_W-1:0] wave_sample(input logic [1:0] sel,
                                                     input logic [INDEX_W-1:0] idx);
      logic [INDEX_W-1:0] i;
      logic [BYTE_W-1:0]  s;
      i = (idx >= INDEX_W'(TABLE_LEN)) ? '0 : idx;
      case (sel)
         WAVE_SQUARE: begin
            // low for the first half, high for the second
            s = (i >= INDEX_W'(TABLE_LEN / 2)) ? 8'd255 : 8'd0;
         end
         WAVE_TRIANGLE: begin
            s = TRIANGLE_TAB[i];
         end
         default: begin
            s = SINE_TAB[i];
         end
      endcase
      return s;
   endfunction

   function automatic logic [PERIOD_W-1:0] period_reset(input logic [LEVEL_W-1:0] lvl);
      logic [PERIOD_W-1:0] p;
      case (lvl)
         CSR_PERIOD_ZERO:  p = 16'd166;
         CSR_PERIOD_ONE:   p = 16'd208;
         CSR_PERIOD_TWO:   p = 16'd277;
         CSR_PERIOD_THREE: p = 16'd416;
         default:          p = 16'd833;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

[rtl/table_waveform_generator_top.sv]
// ----------------------------------------------------------------------------
// table_waveform_generator_top
// Lookup-table waveform generator that emits two-byte SPI frames.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per microsecond tick (action 0) or per received key
//   (action 1). Keys '+' and '-' step the rate level, 't', 'c', 's' pick the
//   triangle, square or sine table. Words are taken one per cycle unless stalled.
//   rsp channel: each frame is two words, the command byte (frame_last 0) and
//   then the sample byte (frame_last 1). A frame's tick loads it into the head
//   register, or into the skid register while the head frame is still being sent;
//   the sample word follows once the command word is taken.
//   Throughput: one request word per cycle while req_stall is low; each frame
//   leaves as two words on the single response port. req_stall rises while a
//   second frame waits behind the one being sent.
//   csr port: registers 0..4 are the tick periods of rate levels 0..4 and
//   live in a five-entry period RAM whose registered read is addressed by the
//   next rate level; register 5 is the command byte.
//   Reset: rate level 0, sine table, timer stopped, sample index 0. Period
//   entries read their default values until written; no clearing pass.
//   A stalled response holds its word; the buffer keeps up to two frames.
// ----------------------------------------------------------------------------
`default_nettype none

module table_waveform_generator_top
   import twg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

`include "table_waveform_generator_top_assert.svh"

   logic [LEVEL_W-1:0]    rate_level_ff, rate_level_in;
   logic [1:0]            wave_sel_ff, wave_sel_in;
   logic                  running_ff, running_in;
   logic [PERIOD_W-1:0]   tick_ff, tick_in;
   logic [INDEX_W-1:0]    index_ff, index_in;
   logic [BYTE_W-1:0]     command_ff;
   logic [NUM_LEVELS-1:0] period_vld_ff;
   logic                  fwd_vld_ff;
   logic [LEVEL_W-1:0]    fwd_addr_ff;
   logic [PERIOD_W-1:0]   fwd_data_ff;

   logic                  accept;
   logic                  full;
   logic                  period_wr;
   logic [PERIOD_W-1:0]   ram_rd_data;
   logic [PERIOD_W-1:0]   period_cur;
   logic [PERIOD_W-1:0]   tick_inc;
   logic                  fire;
   push_type              push;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;
   assign period_wr = csr_wr_en && (csr_index <= CSR_PERIOD_FOUR);

   twg_ram #(
      .WIDTH (PERIOD_W),
      .DEPTH (NUM_LEVELS)
   ) u_period_ram (
      .clock   (clock),
      .wr_en   (period_wr),
      .wr_addr (csr_index),
      .wr_data (csr_wr_data),
      .rd_addr (rate_level_in),
      .rd_data (ram_rd_data)
   );

   // forward a write that landed after the read, else the RAM entry if written, else the default
   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == rate_level_ff)) begin
         period_cur = fwd_data_ff;
      end else if (period_vld_ff[rate_level_ff]) begin
         period_cur = ram_rd_data;
      end else begin
         period_cur = period_reset(rate_level_ff);
      end
   end

   assign tick_inc = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 1'b1;
   assign fire     = accept && (req_data.action == ACTION_TICK) && running_ff &&
                     (tick_inc >= period_cur);

   assign push.valid         = fire;
   assign push.frame.command = command_ff;
   assign push.frame.sample  = wave_sample(wave_sel_ff, index_ff);

   always_comb begin
      rate_level_in = rate_level_ff;
      wave_sel_in   = wave_sel_ff;
      running_in    = running_ff;
      tick_in       = tick_ff;
      index_in      = index_ff;

      if (accept && (req_data.action == ACTION_KEY)) begin
         case (req_data.key_char)
            KEY_FASTER: begin
               if (rate_level_ff != '0) begin
                  rate_level_in = rate_level_ff - 1'b1;
                  running_in    = 1'b1;
                  tick_in       = '0;
               end
            end
            KEY_SLOWER: begin
               if (rate_level_ff < MAX_LEVEL) begin
                  rate_level_in = rate_level_ff + 1'b1;
                  running_in    = 1'b1;
                  tick_in       = '0;
               end
            end
            KEY_TRIANGLE: wave_sel_in = WAVE_TRIANGLE;
            KEY_SQUARE:   wave_sel_in = WAVE_SQUARE;
            KEY_SINE:     wave_sel_in = WAVE_SINE;
            default: begin
            end
         endcase
      end else if (accept && running_ff) begin
         tick_in = fire ? '0 : tick_inc;
         if (fire) begin
            // advance and wrap the shared sample index
            index_in = (index_ff >= INDEX_W'(TABLE_LEN - 1)) ? '0 : index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_level_ff <= '0;
         wave_sel_ff   <= WAVE_SINE;
         running_ff    <= 1'b0;
         tick_ff       <= '0;
         index_ff      <= '0;
         command_ff    <= COMMAND_RESET;
         period_vld_ff <= '0;
         fwd_vld_ff    <= 1'b0;
      end else begin
         rate_level_ff <= rate_level_in;
         wave_sel_ff   <= wave_sel_in;
         running_ff    <= running_in;
         tick_ff       <= tick_in;
         index_ff      <= index_in;
         fwd_vld_ff    <= period_wr;
         if (period_wr) begin
            period_vld_ff[csr_index] <= 1'b1;
         end
         if (csr_wr_en && (csr_index == CSR_COMMAND)) begin
            command_ff <= csr_wr_data[BYTE_W-1:0];
         end
      end
      fwd_addr_ff <= csr_index;
      fwd_data_ff <= csr_wr_data;
   end

   twg_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `TWG_ASSERT_NOW(a_level_in_range, clock, reset, 1'b1, rate_level_ff <= MAX_LEVEL,
      "twg: rate level beyond the last level")
   `TWG_ASSERT_NOW(a_key_no_frame, clock, reset,
      accept && (req_data.action == ACTION_KEY), !push.valid,
      "twg: key word produced a frame")
   `TWG_ASSERT_NEXT(a_fire_clears_count, clock, reset, fire,
      (tick_ff == '0) && running_ff,
      "twg: tick count not cleared after a frame")

endmodule

`default_nettype wire

[rtl/twg_ram.sv]
// ----------------------------------------------------------------------------
// twg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module twg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/twg_out_buf.sv]
// ----------------------------------------------------------------------------
// twg_out_buf
// Two-frame output buffer: serializes each frame into command and sample word.
// ----------------------------------------------------------------------------
`default_nettype none

module twg_out_buf
   import twg_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          full,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

`include "table_waveform_generator_top_assert.svh"

   logic      head_valid_ff, head_valid_in;
   logic      head_phase_ff, head_phase_in;
   frame_type head_ff, head_in;
   logic      skid_valid_ff, skid_valid_in;
   frame_type skid_ff, skid_in;
   logic      pop;
   logic      pop_last;

   assign pop      = head_valid_ff && !rsp_stall;
   assign pop_last = pop && head_phase_ff;
   assign full     = skid_valid_ff;

   assign rsp_valid           = head_valid_ff;
   assign rsp_data.spi_byte   = head_phase_ff ? head_ff.sample : head_ff.command;
   assign rsp_data.frame_last = head_phase_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      head_phase_in = head_phase_ff;
      head_in       = head_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;

      if (pop && !head_phase_ff) begin
         head_phase_in = 1'b1;
      end
      if (pop_last) begin
         head_phase_in = 1'b0;
         head_valid_in = skid_valid_ff;
         head_in       = skid_ff;
         skid_valid_in = 1'b0;
      end

      if (push.valid) begin
         if (!head_valid_ff || pop_last) begin
            head_valid_in = 1'b1;
            head_phase_in = 1'b0;
            head_in       = push.frame;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push.frame;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         head_phase_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         head_phase_ff <= head_phase_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   `TWG_ASSERT_NOW(a_skid_needs_head, clock, reset, skid_valid_ff, head_valid_ff,
      "twg_out_buf: skid frame held without a head frame")
   `TWG_ASSERT_NOW(a_no_push_when_full, clock, reset, push.valid, !skid_valid_ff,
      "twg_out_buf: frame pushed into a full buffer")
   `TWG_ASSERT_NEXT(a_sample_follows_command, clock, reset, pop && !head_phase_ff,
      head_valid_ff && head_phase_ff,
      "twg_out_buf: sample word did not follow command word")

endmodule

`default_nettype wire
